FILE: hw/rtl/par_pkg.sv
package par_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 16;
  localparam int IN_ANGLE_BITS      = 16;
  localparam int MAX_ANGLE_BITS     = 24;
  localparam int WORK_BITS          = 30;
  localparam int SERIES_TERMS       = 6;
  localparam int RECIP_SHIFT        = 32;

  localparam logic [WORK_BITS:0] WORK_ONE = {1'b1, {WORK_BITS{1'b0}}};
  localparam logic [31:0]        PI_Q30   = 32'd3373259426;
  localparam logic [31:0]        SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_NEG  = 32'h8000_0000;

  typedef enum logic [1:0] {
    AXIS_X     = 2'd0,
    AXIS_Y     = 2'd1,
    AXIS_Z_CW  = 2'd2,
    AXIS_Z_CCW = 2'd3
  } par_axis_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } par_quad_t;

  typedef struct packed {
    par_axis_t          req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [15:0]        turn_angle;
  } par_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               clipped;
  } par_out_t;

  // Everything an item carries alongside the series evaluation.
  typedef struct packed {
    par_axis_t              req_type;
    logic signed [31:0]     point_x;
    logic signed [31:0]     point_y;
    logic signed [31:0]     point_z;
    logic signed [31:0]     center_x;
    logic signed [31:0]     center_y;
    logic signed [31:0]     center_z;
    par_quad_t              quad;
    logic                   swap;
    logic [WORK_BITS-1:0]   theta;
  } par_side_t;

  typedef struct packed {
    logic [WORK_BITS-1:0] x2;
    logic [WORK_BITS:0]   t_sin;
    logic [WORK_BITS:0]   t_cos;
    par_side_t            side;
  } par_series_t;

  function automatic logic [7:0] sin_div(input int idx);
    logic [7:0] d;
    unique case (idx)
      0:       d = 8'd156;
      1:       d = 8'd110;
      2:       d = 8'd72;
      3:       d = 8'd42;
      4:       d = 8'd20;
      5:       d = 8'd6;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cos_div(input int idx);
    logic [7:0] d;
    unique case (idx)
      0:       d = 8'd132;
      1:       d = 8'd90;
      2:       d = 8'd56;
      3:       d = 8'd30;
      4:       d = 8'd12;
      5:       d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/par_front.sv
module par_front #(
  parameter int ANGLE_BITS = par_pkg::ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  par_pkg::par_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output par_pkg::par_series_t out_data
);

  localparam int WB       = par_pkg::WORK_BITS;
  localparam int QB       = ANGLE_BITS - 2;
  localparam int EXT_BITS = par_pkg::MAX_ANGLE_BITS;
  localparam int PAD_BITS = par_pkg::MAX_ANGLE_BITS - par_pkg::IN_ANGLE_BITS;
  localparam int PW       = QB + 32;
  localparam int DW       = 2 * WB;

  localparam logic [QB-1:0] EIGHTH = {1'b1, {(QB-1){1'b0}}};
  localparam logic [PW-1:0] RND    = PW'({1'b1, {QB{1'b0}}});

  logic en0, en1, en2;

  logic [EXT_BITS-1:0]   ang_ext;
  logic [ANGLE_BITS-1:0] phase;
  logic [QB-1:0]         rem_raw;
  logic                  fold;
  par_pkg::par_side_t    side0_nxt;

  logic                  s0_v_r;
  par_pkg::par_side_t    s0_side_r;
  logic [QB-1:0]         s0_rem_r;

  logic [PW-1:0]         theta_prod;
  par_pkg::par_side_t    side1_nxt;
  logic                  s1_v_r;
  par_pkg::par_side_t    s1_side_r;

  logic [DW-1:0]         x2_prod;
  logic                  s2_v_r;
  logic [WB-1:0]         s2_x2_r;
  par_pkg::par_side_t    s2_side_r;

  assign en2      = !s2_v_r || out_ready;
  assign en1      = !s1_v_r || en2;
  assign en0      = !s0_v_r || en1;
  assign in_ready = en0;

  // The top ANGLE_BITS of the left-aligned angle give the resized phase.
  assign ang_ext = {in_data.turn_angle, {PAD_BITS{1'b0}}};
  assign phase   = ang_ext[EXT_BITS-1 -: ANGLE_BITS];
  assign rem_raw = phase[QB-1:0];
  assign fold    = rem_raw > EIGHTH;

  always_comb begin
    side0_nxt          = '0;
    side0_nxt.req_type = in_data.req_type;
    side0_nxt.point_x  = in_data.point_x;
    side0_nxt.point_y  = in_data.point_y;
    side0_nxt.point_z  = in_data.point_z;
    side0_nxt.center_x = in_data.center_x;
    side0_nxt.center_y = in_data.center_y;
    side0_nxt.center_z = in_data.center_z;
    side0_nxt.quad     = par_pkg::par_quad_t'(phase[ANGLE_BITS-1 -: 2]);
    side0_nxt.swap     = fold;
  end

  assign theta_prod = PW'(s0_rem_r) * PW'(par_pkg::PI_Q30) + RND;
  assign x2_prod    = DW'(s1_side_r.theta) * DW'(s1_side_r.theta);

  always_comb begin
    side1_nxt       = s0_side_r;
    side1_nxt.theta = theta_prod[ANGLE_BITS-1 +: WB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (en0) s0_v_r <= in_valid;
      if (en1) s1_v_r <= s0_v_r;
      if (en2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      s0_side_r <= side0_nxt;
      // Past the eighth turn the complement is used and sine and cosine swap.
      s0_rem_r  <= fold ? (QB'(0) - rem_raw) : rem_raw;
    end
    if (en1 && s0_v_r) begin
      s1_side_r <= side1_nxt;
    end
    if (en2 && s1_v_r) begin
      s2_side_r <= s1_side_r;
      s2_x2_r   <= x2_prod[DW-1:WB];
    end
  end

  assign out_valid      = s2_v_r;
  assign out_data.x2    = s2_x2_r;
  assign out_data.t_sin = par_pkg::WORK_ONE;
  assign out_data.t_cos = par_pkg::WORK_ONE;
  assign out_data.side  = s2_side_r;

endmodule

FILE: hw/rtl/par_cell.sv
module par_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  par_pkg::par_series_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output par_pkg::par_series_t out_data
);

  localparam int WB = par_pkg::WORK_BITS;
  localparam int MW = 2 * WB + 1;
  localparam int RS = par_pkg::RECIP_SHIFT;
  localparam int QW = WB + RS;
  localparam int CW = WB + 8;

  localparam logic [7:0]    SIN_D = par_pkg::sin_div(IDX);
  localparam logic [7:0]    COS_D = par_pkg::cos_div(IDX);
  localparam logic [RS-1:0] SIN_M = RS'((64'd1 << RS) / SIN_D);
  localparam logic [RS-1:0] COS_M = RS'((64'd1 << RS) / COS_D);

  logic ena, enb, enc;

  logic [MW-1:0] prod_s, prod_c;
  logic          a_v_r;
  logic [WB-1:0] a_ns_r, a_nc_r, a_x2_r;
  par_pkg::par_side_t a_side_r;

  logic [QW-1:0] rq_s, rq_c;
  logic          b_v_r;
  logic [WB-1:0] b_ns_r, b_nc_r, b_qs_r, b_qc_r, b_x2_r;
  par_pkg::par_side_t b_side_r;

  logic [CW-1:0] back_s, back_c;
  logic [WB-1:0] rem_s, rem_c, q_s, q_c;
  par_pkg::par_series_t c_data_nxt;
  logic          c_v_r;
  par_pkg::par_series_t c_data_r;

  assign enc      = !c_v_r || out_ready;
  assign enb      = !b_v_r || enc;
  assign ena      = !a_v_r || enb;
  assign in_ready = ena;

  assign prod_s = MW'(in_data.x2) * MW'(in_data.t_sin);
  assign prod_c = MW'(in_data.x2) * MW'(in_data.t_cos);

  // Quotient by reciprocal; the estimate is exact or one short.
  assign rq_s = QW'(a_ns_r) * QW'(SIN_M);
  assign rq_c = QW'(a_nc_r) * QW'(COS_M);

  assign back_s = CW'(b_qs_r) * CW'(SIN_D);
  assign back_c = CW'(b_qc_r) * CW'(COS_D);
  assign rem_s  = b_ns_r - back_s[WB-1:0];
  assign rem_c  = b_nc_r - back_c[WB-1:0];
  assign q_s    = b_qs_r + WB'(rem_s >= WB'(SIN_D));
  assign q_c    = b_qc_r + WB'(rem_c >= WB'(COS_D));

  always_comb begin
    c_data_nxt.x2    = b_x2_r;
    c_data_nxt.t_sin = par_pkg::WORK_ONE - {1'b0, q_s};
    c_data_nxt.t_cos = par_pkg::WORK_ONE - {1'b0, q_c};
    c_data_nxt.side  = b_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (ena) a_v_r <= in_valid;
      if (enb) b_v_r <= a_v_r;
      if (enc) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena && in_valid) begin
      a_ns_r   <= prod_s[2*WB-1:WB];
      a_nc_r   <= prod_c[2*WB-1:WB];
      a_x2_r   <= in_data.x2;
      a_side_r <= in_data.side;
    end
    if (enb && a_v_r) begin
      b_ns_r   <= a_ns_r;
      b_nc_r   <= a_nc_r;
      b_qs_r   <= rq_s[QW-1:RS];
      b_qc_r   <= rq_c[QW-1:RS];
      b_x2_r   <= a_x2_r;
      b_side_r <= a_side_r;
    end
    if (enc && b_v_r) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_data  = c_data_r;

endmodule

FILE: hw/rtl/par_back.sv
module par_back #(
  parameter int TRIG_FRAC_BITS = par_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  par_pkg::par_series_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output par_pkg::par_out_t    out_data
);

  localparam int WB  = par_pkg::WORK_BITS;
  localparam int MW  = 2 * WB + 1;
  localparam int SH  = WB - TRIG_FRAC_BITS;
  localparam int TU  = TRIG_FRAC_BITS + 1;
  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int DLW = 33;
  localparam int PWD = DLW + TW;
  localparam int SW  = PWD + 1;
  localparam int RW  = SW - TRIG_FRAC_BITS;
  localparam int CW  = RW + 1;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (TRIG_FRAC_BITS - 1);

  function automatic logic [TU-1:0] to_trig(input logic [WB:0] v);
    logic [WB+1:0] t;
    t = {v, 1'b0} + ((WB + 2)'(1) << SH);
    return t[SH+1 +: TU];
  endfunction

  function automatic logic [31:0] clamp(input logic signed [CW-1:0] v);
    logic fits;
    fits = (&v[CW-1:31]) || !(|v[CW-1:31]);
    priority if (fits) return v[31:0];
    else if (v[CW-1]) return par_pkg::SAT_NEG;
    else return par_pkg::SAT_POS;
  endfunction

  logic en0, en1, en2, en3, en4;

  // stage 0: sine series times theta
  logic [MW-1:0]      sv_prod;
  logic               b0_v_r;
  logic [WB:0]        b0_sv_r, b0_cv_r;
  par_pkg::par_side_t b0_side_r;

  // stage 1: signed sine and cosine, operand selection
  logic [TU-1:0]          s0u, c0u;
  logic signed [TW-1:0]   s0, c0, s_q, c_q, s_eff;
  logic signed [DLW-1:0]  dx, dy, dz, a_sel, b_sel;
  logic signed [31:0]     ca_sel, cb_sel;
  logic                   b1_v_r;
  logic signed [TW-1:0]   b1_s_r, b1_c_r;
  logic signed [DLW-1:0]  b1_a_r, b1_b_r;
  logic signed [31:0]     b1_ca_r, b1_cb_r;
  par_pkg::par_side_t     b1_side_r;

  // stage 2: products
  logic                   b2_v_r;
  logic signed [PWD-1:0]  b2_ac_r, b2_bs_r, b2_as_r, b2_bc_r;
  logic signed [31:0]     b2_ca_r, b2_cb_r;
  par_pkg::par_side_t     b2_side_r;

  // stage 3: sums and rounding
  logic signed [SW-1:0]   sum_u, sum_w, sh_u, sh_w;
  logic                   b3_v_r;
  logic signed [RW-1:0]   b3_u_r, b3_w_r;
  logic signed [31:0]     b3_ca_r, b3_cb_r;
  par_pkg::par_side_t     b3_side_r;

  // stage 4: centre, saturation, result
  logic signed [CW-1:0]   fin_u, fin_w;
  logic [31:0]            sat_u, sat_w;
  logic                   clip_u, clip_w;
  par_pkg::par_out_t      res_nxt;
  logic                   b4_v_r;
  par_pkg::par_out_t      b4_out_r;

  assign en4      = !b4_v_r || out_ready;
  assign en3      = !b3_v_r || en4;
  assign en2      = !b2_v_r || en3;
  assign en1      = !b1_v_r || en2;
  assign en0      = !b0_v_r || en1;
  assign in_ready = en0;

  assign sv_prod = MW'(in_data.side.theta) * MW'(in_data.t_sin);

  assign s0u = to_trig(b0_side_r.swap ? b0_cv_r : b0_sv_r);
  assign c0u = to_trig(b0_side_r.swap ? b0_sv_r : b0_cv_r);
  assign s0  = $signed({1'b0, s0u});
  assign c0  = $signed({1'b0, c0u});

  assign dx = DLW'($signed(b0_side_r.point_x)) - DLW'($signed(b0_side_r.center_x));
  assign dy = DLW'($signed(b0_side_r.point_y)) - DLW'($signed(b0_side_r.center_y));
  assign dz = DLW'($signed(b0_side_r.point_z)) - DLW'($signed(b0_side_r.center_z));

  always_comb begin
    unique case (b0_side_r.quad)
      par_pkg::QUAD_FIRST: begin
        s_q = s0;
        c_q = c0;
      end
      par_pkg::QUAD_SECOND: begin
        s_q = c0;
        c_q = -s0;
      end
      par_pkg::QUAD_THIRD: begin
        s_q = -s0;
        c_q = -c0;
      end
      par_pkg::QUAD_FOURTH: begin
        s_q = -c0;
        c_q = s0;
      end
    endcase
  end

  // All four axes share u = a*c - b*s, w = a*s + b*c; Y and clockwise Z flip s.
  always_comb begin
    unique case (b0_side_r.req_type)
      par_pkg::AXIS_X: begin
        a_sel  = dy;
        b_sel  = dz;
        ca_sel = b0_side_r.center_y;
        cb_sel = b0_side_r.center_z;
        s_eff  = s_q;
      end
      par_pkg::AXIS_Y: begin
        a_sel  = dx;
        b_sel  = dz;
        ca_sel = b0_side_r.center_x;
        cb_sel = b0_side_r.center_z;
        s_eff  = -s_q;
      end
      par_pkg::AXIS_Z_CW: begin
        a_sel  = dx;
        b_sel  = dy;
        ca_sel = b0_side_r.center_x;
        cb_sel = b0_side_r.center_y;
        s_eff  = -s_q;
      end
      par_pkg::AXIS_Z_CCW: begin
        a_sel  = dx;
        b_sel  = dy;
        ca_sel = b0_side_r.center_x;
        cb_sel = b0_side_r.center_y;
        s_eff  = s_q;
      end
    endcase
  end

  assign sum_u = SW'(b2_ac_r) - SW'(b2_bs_r) + RND_HALF;
  assign sum_w = SW'(b2_as_r) + SW'(b2_bc_r) + RND_HALF;
  assign sh_u  = sum_u >>> TRIG_FRAC_BITS;
  assign sh_w  = sum_w >>> TRIG_FRAC_BITS;

  assign fin_u  = CW'(b3_u_r) + CW'(b3_ca_r);
  assign fin_w  = CW'(b3_w_r) + CW'(b3_cb_r);
  assign sat_u  = clamp(fin_u);
  assign sat_w  = clamp(fin_w);
  assign clip_u = !((&fin_u[CW-1:31]) || !(|fin_u[CW-1:31]));
  assign clip_w = !((&fin_w[CW-1:31]) || !(|fin_w[CW-1:31]));

  always_comb begin
    res_nxt.rotated_x = b3_side_r.point_x;
    res_nxt.rotated_y = b3_side_r.point_y;
    res_nxt.rotated_z = b3_side_r.point_z;
    res_nxt.clipped   = clip_u || clip_w;
    unique case (b3_side_r.req_type)
      par_pkg::AXIS_X: begin
        res_nxt.rotated_y = sat_u;
        res_nxt.rotated_z = sat_w;
      end
      par_pkg::AXIS_Y: begin
        res_nxt.rotated_x = sat_u;
        res_nxt.rotated_z = sat_w;
      end
      par_pkg::AXIS_Z_CW, par_pkg::AXIS_Z_CCW: begin
        res_nxt.rotated_x = sat_u;
        res_nxt.rotated_y = sat_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else begin
      if (en0) b0_v_r <= in_valid;
      if (en1) b1_v_r <= b0_v_r;
      if (en2) b2_v_r <= b1_v_r;
      if (en3) b3_v_r <= b2_v_r;
      if (en4) b4_v_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      b0_sv_r   <= {1'b0, sv_prod[2*WB-1:WB]};
      b0_cv_r   <= in_data.t_cos;
      b0_side_r <= in_data.side;
    end
    if (en1 && b0_v_r) begin
      b1_s_r    <= s_eff;
      b1_c_r    <= c_q;
      b1_a_r    <= a_sel;
      b1_b_r    <= b_sel;
      b1_ca_r   <= ca_sel;
      b1_cb_r   <= cb_sel;
      b1_side_r <= b0_side_r;
    end
    if (en2 && b1_v_r) begin
      b2_ac_r   <= PWD'(b1_a_r) * PWD'(b1_c_r);
      b2_bs_r   <= PWD'(b1_b_r) * PWD'(b1_s_r);
      b2_as_r   <= PWD'(b1_a_r) * PWD'(b1_s_r);
      b2_bc_r   <= PWD'(b1_b_r) * PWD'(b1_c_r);
      b2_ca_r   <= b1_ca_r;
      b2_cb_r   <= b1_cb_r;
      b2_side_r <= b1_side_r;
    end
    if (en3 && b2_v_r) begin
      b3_u_r    <= sh_u[RW-1:0];
      b3_w_r    <= sh_w[RW-1:0];
      b3_ca_r   <= b2_ca_r;
      b3_cb_r   <= b2_cb_r;
      b3_side_r <= b2_side_r;
    end
    if (en4 && b3_v_r) begin
      b4_out_r <= res_nxt;
    end
  end

  assign out_valid = b4_v_r;
  assign out_data  = b4_out_r;

endmodule

FILE: hw/rtl/point_axis_rotator.sv
// Throughput: one request per cycle unless out_ready stalls the output; the
// datapath is fully pipelined, three front stages, six series cells of three
// stages each and five output stages.
// A stalled output fills empty stages first, so requests keep entering.
// Reset: synchronous active-low rst_n clears every stage valid; no data reset.
module point_axis_rotator #(
  parameter int ANGLE_BITS     = par_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = par_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  par_pkg::par_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output par_pkg::par_out_t out_data
);

  localparam int NC = par_pkg::SERIES_TERMS;

  logic [NC:0]          lnk_v;
  logic [NC:0]          lnk_rdy;
  par_pkg::par_series_t lnk_d [NC+1];

  par_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (lnk_v[0]),
    .out_ready (lnk_rdy[0]),
    .out_data  (lnk_d[0])
  );

  // One Horner step of both the sine and the cosine series per cell.
  for (genvar gi = 0; gi < NC; gi++) begin : g_cell
    par_cell #(
      .IDX(gi)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lnk_v[gi]),
      .in_ready  (lnk_rdy[gi]),
      .in_data   (lnk_d[gi]),
      .out_valid (lnk_v[gi+1]),
      .out_ready (lnk_rdy[gi+1]),
      .out_data  (lnk_d[gi+1])
    );
  end

  par_back #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lnk_v[NC]),
    .in_ready  (lnk_rdy[NC]),
    .in_data   (lnk_d[NC]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
